/* src/acalu_pkg.sv */
// ----------------------------------------------------------------------------
// acalu_pkg
// Shared codes, types and saturating arithmetic helpers for the accumulator
// ALU with undo.
// ----------------------------------------------------------------------------
`default_nettype none

package acalu_pkg;

    localparam int DEF_HISTORY_DEPTH = 64;
    localparam int DEF_FRAC_BITS     = 32;

    // Request codes on the input port.
    localparam logic [2:0] REQ_ADD  = 3'd0;
    localparam logic [2:0] REQ_SUB  = 3'd1;
    localparam logic [2:0] REQ_MUL  = 3'd2;
    localparam logic [2:0] REQ_DIV  = 3'd3;
    localparam logic [2:0] REQ_UNDO = 3'd4;

    // Classified operations between the front and the back.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_UNDO = 3'd4;
    localparam logic [2:0] OP_DIVZ = 3'd5;
    localparam logic [2:0] OP_NOP  = 3'd6;

    // Status codes on the result port.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
    localparam logic [1:0] ST_NO_UNDO   = 2'd2;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] opd;
    } t_item;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Saturated signed value from a sign and an unsigned magnitude.
    function automatic logic [63:0] sat_mag(input logic neg, input logic [127:0] m);
        logic [63:0] r;
        if (neg) begin
            r = (m > {64'd0, SMIN}) ? SMIN : (64'd0 - m[63:0]);
        end else begin
            r = (m > {64'd0, SMAX}) ? SMAX : m[63:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            r = a[63] ? SMIN : SMAX;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
            r = a[63] ? SMIN : SMAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/accumulator_alu_with_undo.sv */
// ----------------------------------------------------------------------------
// accumulator_alu_with_undo
// Signed fixed-point accumulator with saturating add, subtract, multiply and
// divide, and an undo stack of earlier totals.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word. A two-entry queue takes words
// while the back end works; the back end handles one word at a time once the
// result register is free. Add, subtract, undo refusals, divide by zero and
// unused codes load the result straight from the idle state; an undo waits
// for one registered read of the history memory, a multiply for four 32x32
// partial products, and a divide for the restoring divider that produces one
// quotient bit per cycle.
`default_nettype none

module accumulator_alu_with_undo #(
    parameter int  HISTORY_DEPTH = acalu_pkg::DEF_HISTORY_DEPTH,
    parameter int  FRAC_BITS     = acalu_pkg::DEF_FRAC_BITS,
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [2:0]        i_req_type,
    input  wire logic [63:0]       i_operand_value,
    output logic                   empty,
    input  wire logic              pop,
    output logic [63:0]            o_total_value,
    output logic [1:0]             o_status,
    output logic [CNT_W-1:0]       o_history_count
);
    import acalu_pkg::*;

    logic  item_valid;
    logic  item_pop;
    t_item item;

    acalu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_req_type      (i_req_type),
        .i_operand_value (i_operand_value),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_item_pop      (item_pop)
    );

    acalu_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (item_valid),
        .i_item          (item),
        .o_item_pop      (item_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_total_value   (o_total_value),
        .o_status        (o_status),
        .o_history_count (o_history_count)
    );

endmodule

`default_nettype wire

/* src/acalu_front.sv */
// ----------------------------------------------------------------------------
// acalu_front
// Accepts request words, classifies them and holds them in a two-entry queue
// for the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module acalu_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [2:0]        i_req_type,
    input  wire logic [63:0]       i_operand_value,
    output logic                   o_item_valid,
    output acalu_pkg::t_item       o_item,
    input  wire logic              i_item_pop
);
    import acalu_pkg::*;

    t_item       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        accept;
    t_item       cls;

    assign o_full       = (r_count == 2'd2);
    assign accept       = i_push && !o_full;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rd_ptr];

    always_comb begin
        cls.opd = i_operand_value;
        case (i_req_type)
            REQ_ADD:  cls.op = OP_ADD;
            REQ_SUB:  cls.op = OP_SUB;
            REQ_MUL:  cls.op = OP_MUL;
            REQ_DIV:  cls.op = (i_operand_value == 64'd0) ? OP_DIVZ : OP_DIV;
            REQ_UNDO: cls.op = OP_UNDO;
            default:  cls.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (accept) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_item_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, accept} - {1'b0, i_item_pop};
        end
    end

endmodule

`default_nettype wire

/* src/acalu_mul.sv */
// ----------------------------------------------------------------------------
// acalu_mul
// Fixed-point multiplier built from four 32x32 partial products, one per
// cycle, accumulated into a 128-bit magnitude and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module acalu_mul #(
    parameter int FRAC_BITS = acalu_pkg::DEF_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_result
);
    import acalu_pkg::*;

    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sh;
    logic         r_pp_vld;
    logic         r_pp_last;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_shifted;

    assign a_half = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
    assign b_half = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];

    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_shifted = {64'd0, r_pp};
            2'd1:    pp_shifted = {32'd0, r_pp, 32'd0};
            default: pp_shifted = {r_pp, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_pp_vld <= 1'b0;
            r_cnt    <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_pp_vld <= 1'b0;
                r_cnt    <= 3'd0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_cnt <= r_cnt + 3'd1;
                end
                r_pp_vld <= (r_cnt != 3'd4);
                if (r_pp_vld && r_pp_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= mag64(i_a);
            r_mb  <= mag64(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= 128'd0;
        end else if (r_busy) begin
            r_pp      <= {32'd0, a_half} * {32'd0, b_half};
            r_pp_sh   <= {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
            r_pp_last <= (r_cnt == 3'd3);
            if (r_pp_vld) begin
                r_acc <= r_acc + pp_shifted;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = sat_mag(r_neg, r_acc >> FRAC_BITS);

endmodule

`default_nettype wire

/* src/acalu_div.sv */
// ----------------------------------------------------------------------------
// acalu_div
// Restoring fixed-point divider: one quotient bit per cycle over the scaled
// numerator, truncating toward zero, then saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module acalu_div #(
    parameter int FRAC_BITS = acalu_pkg::DEF_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_result
);
    import acalu_pkg::*;

    localparam int NUM_W = 64 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_q;
    logic [63:0]      r_rem;
    logic [63:0]      r_mb;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [64:0]      rem2;
    logic             qbit;
    logic [64:0]      rem_sub;

    assign rem2    = {r_rem, r_num[NUM_W-1]};
    assign qbit    = (rem2 >= {1'b0, r_mb});
    assign rem_sub = rem2 - {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_W'(mag64(i_a)) << FRAC_BITS;
            r_mb  <= mag64(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_rem <= 64'd0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_q   <= {r_q[NUM_W-2:0], qbit};
            r_rem <= qbit ? rem_sub[63:0] : rem2[63:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = sat_mag(r_neg, 128'(r_q));

endmodule

`default_nettype wire

/* src/acalu_back.sv */
// ----------------------------------------------------------------------------
// acalu_back
// Execution back end: running total, history stack memory, sequencing of the
// multiplier and divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module acalu_back #(
    parameter int  HISTORY_DEPTH = acalu_pkg::DEF_HISTORY_DEPTH,
    parameter int  FRAC_BITS     = acalu_pkg::DEF_FRAC_BITS,
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    input  wire acalu_pkg::t_item  i_item,
    output logic                   o_item_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [63:0]            o_total_value,
    output logic [1:0]             o_status,
    output logic [CNT_W-1:0]       o_history_count
);
    import acalu_pkg::*;

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_UNDO = 2'd3;

    logic [63:0]      r_mem [HISTORY_DEPTH];
    logic [63:0]      r_rd_data;
    logic [1:0]       r_state,   n_state;
    logic [63:0]      r_total,   n_total;
    logic [CNT_W-1:0] r_fill,    n_fill;
    logic [PTR_W-1:0] r_top,     n_top;
    logic [1:0]       n_status;
    logic             r_out_valid;
    logic [63:0]      r_out_total;
    logic [1:0]       r_out_status;
    logic [CNT_W-1:0] r_out_count;
    logic             start;
    logic             out_load;
    logic             mem_we;
    logic             mul_start;
    logic             div_start;
    logic             mul_done;
    logic             div_done;
    logic [63:0]      mul_res;
    logic [63:0]      div_res;
    logic [PTR_W-1:0] top_inc;
    logic [PTR_W-1:0] top_dec;

    assign start      = i_item_valid && (r_state == S_IDLE) && !r_out_valid;
    assign o_item_pop = start;
    assign top_inc = (r_top == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_top + 1'b1;
    assign top_dec = (r_top == '0) ? PTR_W'(HISTORY_DEPTH - 1) : r_top - 1'b1;

    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_fill    = r_fill;
        n_top     = r_top;
        n_status  = ST_OK;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.op)
                        OP_ADD: begin
                            mem_we   = 1'b1;
                            n_total  = sat_add(r_total, i_item.opd);
                            out_load = 1'b1;
                        end
                        OP_SUB: begin
                            mem_we   = 1'b1;
                            n_total  = sat_sub(r_total, i_item.opd);
                            out_load = 1'b1;
                        end
                        OP_MUL: begin
                            mem_we    = 1'b1;
                            mul_start = 1'b1;
                            n_state   = S_MUL;
                        end
                        OP_DIV: begin
                            mem_we    = 1'b1;
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                        OP_DIVZ: begin
                            n_status = ST_DIV_ZERO;
                            out_load = 1'b1;
                        end
                        OP_UNDO: begin
                            if (r_fill == '0) begin
                                n_status = ST_NO_UNDO;
                                out_load = 1'b1;
                            end else begin
                                // The saved total arrives from the memory next cycle.
                                n_top   = top_dec;
                                n_fill  = r_fill - 1'b1;
                                n_state = S_UNDO;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                    if (mem_we) begin
                        n_top = top_inc;
                        if (r_fill != CNT_W'(HISTORY_DEPTH)) begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_total  = mul_res;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_total  = div_res;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_UNDO: begin
                n_total  = r_rd_data;
                out_load = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_top] <= r_total;
        end
        r_rd_data <= r_mem[top_dec];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= 64'd0;
            r_fill      <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_fill  <= n_fill;
            r_top   <= n_top;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_total  <= n_total;
            r_out_status <= n_status;
            r_out_count  <= n_fill;
        end
    end

    acalu_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (r_total),
        .i_b      (i_item.opd),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    acalu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_a      (r_total),
        .i_b      (i_item.opd),
        .o_done   (div_done),
        .o_result (div_res)
    );

    assign o_empty         = !r_out_valid;
    assign o_total_value   = r_out_total;
    assign o_status        = r_out_status;
    assign o_history_count = r_out_count;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(HISTORY_DEPTH))
        else $error("history fill beyond depth");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == S_MUL)
        else $error("multiplier finished outside its state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside its state");

    a_no_undo_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_NO_UNDO) |-> r_out_count == '0)
        else $error("undo refused with history present");
`endif

endmodule

`default_nettype wire

/* bench/accumulator_alu_with_undo_tb.sv */
// ----------------------------------------------------------------------------
// accumulator_alu_with_undo_tb
// Self-checking bench for the fixed-point accumulator with undo. Requests go
// in through the push/full side, every result word is popped and compared
// with a predicted total, status and undo depth.
// ----------------------------------------------------------------------------
`default_nettype none

class acc_scoreboard;
    localparam int DEPTH = acalu_pkg::DEF_HISTORY_DEPTH;
    localparam int FRAC  = acalu_pkg::DEF_FRAC_BITS;

    typedef struct packed {
        logic [63:0] total;
        logic [1:0]  status;
        logic [6:0]  depth;
    } t_outcome;

    logic [63:0] total;
    logic [63:0] saved_totals [DEPTH];
    int          fill;
    int          top;
    t_outcome    pending [$];
    int          errors;
    int          checked;
    int          undo_count;
    int          refusals;

    function new();
        total = '0;
        fill = 0;
        top = 0;
        errors = 0;
        checked = 0;
        undo_count = 0;
        refusals = 0;
    endfunction

    function automatic logic [63:0] clamp(input logic neg, input logic [127:0] m);
        if (neg) begin
            return (m > 128'h8000_0000_0000_0000) ? acalu_pkg::SMIN : (64'd0 - m[63:0]);
        end
        return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? acalu_pkg::SMAX : m[63:0];
    endfunction

    function automatic logic [63:0] magn(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function void save_total();
        saved_totals[top] = total;
        top = (top + 1) % DEPTH;
        if (fill < DEPTH) fill++;
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(input logic [2:0] req, input logic [63:0] opd);
        logic [63:0]  r;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [1:0]   st;
        st = acalu_pkg::ST_OK;
        case (req)
            acalu_pkg::REQ_ADD: begin
                save_total();
                r = total + opd;
                if (total[63] == opd[63] && r[63] != total[63])
                    r = total[63] ? acalu_pkg::SMIN : acalu_pkg::SMAX;
                total = r;
            end
            acalu_pkg::REQ_SUB: begin
                save_total();
                r = total - opd;
                if (total[63] != opd[63] && r[63] != total[63])
                    r = total[63] ? acalu_pkg::SMIN : acalu_pkg::SMAX;
                total = r;
            end
            acalu_pkg::REQ_MUL: begin
                save_total();
                prod = {64'd0, magn(total)} * {64'd0, magn(opd)};
                total = clamp(total[63] != opd[63], prod >> FRAC);
            end
            acalu_pkg::REQ_DIV: begin
                if (opd == '0) begin
                    st = acalu_pkg::ST_DIV_ZERO;
                    refusals++;
                end else begin
                    save_total();
                    quo = ({64'd0, magn(total)} << FRAC) / {64'd0, magn(opd)};
                    total = clamp(total[63] != opd[63], quo);
                end
            end
            acalu_pkg::REQ_UNDO: begin
                if (fill == 0) begin
                    st = acalu_pkg::ST_NO_UNDO;
                    refusals++;
                end else begin
                    top = (top + DEPTH - 1) % DEPTH;
                    total = saved_totals[top];
                    fill--;
                    undo_count++;
                end
            end
            default: ;
        endcase
        pending.push_back('{total: total, status: st, depth: 7'(fill)});
    endfunction

    function void check_result(input logic [63:0] tot, input logic [1:0] st,
                               input logic [6:0] dep);
        t_outcome e;
        checked++;
        if (pending.size() == 0) begin
            $error("result word with no expectation waiting");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (tot !== e.total) begin
            $error("total_value: expected %h, actual %h", e.total, tot);
            errors++;
        end
        if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
        end
        if (dep !== e.depth) begin
            $error("history_count: expected %0d, actual %0d", e.depth, dep);
            errors++;
        end
    endfunction
endclass

module accumulator_alu_with_undo_tb;
    import acalu_pkg::*;

    localparam int N_RANDOM = 440;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    wire         full;
    logic [2:0]  i_req_type;
    logic [63:0] i_operand_value;
    wire         empty;
    logic        pop;
    wire [63:0]  o_total_value;
    wire [1:0]   o_status;
    wire [6:0]   o_history_count;

    acc_scoreboard sb;
    bit   idle_allowed;
    bit   long_hold;

    accumulator_alu_with_undo i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_req_type(i_req_type), .i_operand_value(i_operand_value),
        .empty(empty), .pop(pop),
        .o_total_value(o_total_value), .o_status(o_status),
        .o_history_count(o_history_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offers one request and holds it until the block takes it. Push stays
    // high into the next request unless an idle gap follows.
    task automatic send_request(input logic [2:0] req, input logic [63:0] opd);
        push <= 1'b1;
        i_req_type <= req;
        i_operand_value <= opd;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        sb.note_request(req, opd);
        @(negedge i_clk);
        if (idle_allowed && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return {$urandom, $urandom};
            1: return 64'(signed'($urandom_range(0, 40)) - 20) << 32;
            2: return {{32{1'b0}}, $urandom};
            3: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
            4: return ($urandom_range(0, 1)) ? SMAX : SMIN;
            5: return '0;
            default: return {{30{$urandom_range(0, 1) == 1}}, 2'($urandom_range(0, 3)),
                             $urandom};
        endcase
    endfunction

    // Receiver: pops at random, with one long hold-off while words pile up.
    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                pop <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (idle_allowed && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_total_value, o_status, o_history_count);
        end
    end

    initial begin
        logic [2:0] req;
        int wait_cycles;
        sb = new();
        push = 1'b0;
        i_req_type = REQ_ADD;
        i_operand_value = '0;
        i_rst_n = 1'b0;
        idle_allowed = 1'b1;
        long_hold = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty undo, extremes, divide by zero, unused codes.
        send_request(REQ_UNDO, '0);
        send_request(REQ_ADD, SMAX);
        send_request(REQ_ADD, 64'd1);
        send_request(REQ_SUB, SMIN);
        send_request(REQ_MUL, SMAX);
        send_request(REQ_MUL, 64'hFFFF_FFFF_0000_0000);
        send_request(REQ_DIV, '0);
        send_request(REQ_DIV, 64'd1);
        send_request(REQ_DIV, SMIN);
        send_request(REQ_SUB, 64'h0000_0003_8000_0000);
        send_request(REQ_DIV, 64'hFFFF_FFFE_0000_0000);
        send_request(REQ_MUL, 64'h0000_0000_0000_0001);
        send_request(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(3'd6, '0);
        send_request(3'd7, SMIN);
        send_request(REQ_UNDO, '0);
        send_request(REQ_UNDO, '0);
        send_request(REQ_ADD, SMIN);
        send_request(REQ_SUB, 64'd1);

        // Long receiver stall while requests keep coming.
        long_hold = 1'b1;
        repeat (12) send_request(REQ_ADD, 64'h0000_0001_0000_0000);

        // Random mix; runs of pushes wrap the history ring, runs of undos drain it.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 150) idle_allowed = 1'b0;
            if (i % 200 == 50) begin
                repeat (70) send_request(3'($urandom_range(0, 3)), pick_operand() | 64'd1);
                repeat (75) send_request(REQ_UNDO, pick_operand());
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3:     req = REQ_ADD;
                4, 5, 6, 7:     req = REQ_SUB;
                8, 9, 10:       req = REQ_MUL;
                11, 12, 13:     req = REQ_DIV;
                14, 15, 16, 17: req = REQ_UNDO;
                default:        req = 3'($urandom_range(5, 7));
            endcase
            send_request(req, pick_operand());
        end
        push <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(negedge i_clk);

        $display("Checked %0d result words: %0d undos taken, %0d refusals.",
                 sb.checked, sb.undo_count, sb.refusals);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
